// ===== hdl/ppc_pkg.sv =====
// shared types, constants and lane tables of the pedal position plausibility block
// no dependencies; every other file of the block refers to it by scoped names
package ppc_pkg;

    localparam int CODE_W   = 12;
    localparam int STATE_W  = 20;
    localparam int LEVEL_W  = 17;
    localparam int FRAC_W   = 16;
    localparam int BRAKE_W  = 16;
    localparam int TIME_W   = 32;
    localparam int FTIME_W  = 16;
    localparam int ALPHA_W  = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // filter product: signed alpha times signed difference
    localparam int DIFF_W = STATE_W + 2;
    localparam int PROD_W = DIFF_W + ALPHA_W + 1;

    // reciprocal scaling for the travel mapping
    localparam int RECIP_SHIFT = STATE_W + FRAC_W;
    localparam int RECIP_W     = RECIP_SHIFT - 8 + 1;
    localparam int MUL_W       = STATE_W + RECIP_W;
    localparam int EST_LSB     = RECIP_SHIFT - FRAC_W;
    localparam int REM_W       = LEVEL_W + STATE_W;

    localparam logic [LEVEL_W-1:0] ONE_Q16   = LEVEL_W'(65536);
    localparam logic [STATE_W-1:0] STATE_MAX = '1;

    localparam int SENSOR_ONE_REST      = 400;
    localparam int SENSOR_ONE_FULL      = 3600;
    localparam int SENSOR_TWO_REST      = 400;
    localparam int SENSOR_TWO_FULL      = 3600;
    localparam int BRAKE_ON_LEVEL       = 1000;
    localparam int THROTTLE_RESET_LEVEL = 3277;

    localparam logic [BRAKE_W-1:0]   BRAKE_ON     = BRAKE_W'(BRAKE_ON_LEVEL);
    localparam logic [LEVEL_W:0]     THROTTLE_LOW = (LEVEL_W + 1)'(2 * THROTTLE_RESET_LEVEL);

    typedef struct packed {
        logic                 span_ok;
        logic [STATE_W-1:0]   rest_q8;
        logic [STATE_W-1:0]   span;
        logic [RECIP_W-1:0]   recip;
    } lane_const_t;

    localparam int     ONE_SPAN  = (SENSOR_ONE_FULL - SENSOR_ONE_REST) * 256;
    localparam int     TWO_SPAN  = (SENSOR_TWO_FULL - SENSOR_TWO_REST) * 256;
    localparam longint ONE_RECIP = (longint'(1) << RECIP_SHIFT) / ((ONE_SPAN > 0) ? ONE_SPAN : 1);
    localparam longint TWO_RECIP = (longint'(1) << RECIP_SHIFT) / ((TWO_SPAN > 0) ? TWO_SPAN : 1);

    localparam lane_const_t LANE_ONE = '{
        span_ok: 1'(ONE_SPAN > 0),
        rest_q8: STATE_W'(SENSOR_ONE_REST * 256),
        span:    STATE_W'((ONE_SPAN > 0) ? ONE_SPAN : 1),
        recip:   RECIP_W'(ONE_RECIP)
    };
    localparam lane_const_t LANE_TWO = '{
        span_ok: 1'(TWO_SPAN > 0),
        rest_q8: STATE_W'(SENSOR_TWO_REST * 256),
        span:    STATE_W'((TWO_SPAN > 0) ? TWO_SPAN : 1),
        recip:   RECIP_W'(TWO_RECIP)
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_ALPHA   = 3'd0,
        REG_ONE_LOW_LIMIT  = 3'd1,
        REG_ONE_HIGH_LIMIT = 3'd2,
        REG_TWO_LOW_LIMIT  = 3'd3,
        REG_TWO_HIGH_LIMIT = 3'd4,
        REG_FAULT_TIME     = 3'd5,
        REG_DISAGREE_LIMIT = 3'd6,
        REG_THROTTLE_ON    = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FILTER_MUL,
        PH_FILTER_ADD,
        PH_MAP_MUL,
        PH_MAP_FIX,
        PH_MERGE
    } phase_t;

    typedef struct packed {
        logic filter_mul;
        logic filter_add;
        logic map_mul;
        logic map_fix;
    } lane_ctrl_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] throttle_level;
        logic [LEVEL_W-1:0] sensor_one_level;
        logic [LEVEL_W-1:0] sensor_two_level;
        logic               pedal_fault;
        logic               brake_conflict_fault;
    } result_t;

endpackage

// ===== hdl/ppc_if.sv =====
// sample and result channel interfaces of the pedal position plausibility block
// depends on ppc_pkg for field widths
interface ppc_sample_if;
    logic                          valid;
    logic                          ready;
    logic [ppc_pkg::CODE_W-1:0]    sensor_one_code;
    logic [ppc_pkg::CODE_W-1:0]    sensor_two_code;
    logic [ppc_pkg::BRAKE_W-1:0]   brake_front;
    logic [ppc_pkg::BRAKE_W-1:0]   brake_rear;
    logic [ppc_pkg::TIME_W-1:0]    now_ms;

    modport source (
        output valid, sensor_one_code, sensor_two_code, brake_front, brake_rear, now_ms,
        input  ready
    );
    modport sink (
        input  valid, sensor_one_code, sensor_two_code, brake_front, brake_rear, now_ms,
        output ready
    );
endinterface

interface ppc_result_if;
    logic                          valid;
    logic                          ready;
    logic [ppc_pkg::LEVEL_W-1:0]   throttle_level;
    logic [ppc_pkg::LEVEL_W-1:0]   sensor_one_level;
    logic [ppc_pkg::LEVEL_W-1:0]   sensor_two_level;
    logic                          pedal_fault;
    logic                          brake_conflict_fault;

    modport source (
        output valid, throttle_level, sensor_one_level, sensor_two_level, pedal_fault,
               brake_conflict_fault,
        input  ready
    );
    modport sink (
        input  valid, throttle_level, sensor_one_level, sensor_two_level, pedal_fault,
               brake_conflict_fault,
        output ready
    );
endinterface

// ===== hdl/pedal_position_plausibility_top.sv =====
// top level of the pedal position plausibility block: configuration, sequencer, lanes, merge
// depends on ppc_pkg, ppc_if, ppc_lane and ppc_merge
//
// two pedal sensor lanes run side by side on each sample: each low-pass filters
// its code in q12.8, maps it from rest to full travel into a clamped q1.16
// fraction and tests it against its healthy window; a merge stage then raises
// the pedal fault on range timeout or sensor disagreement and keeps the brake
// conflict latch. one sample is in flight at a time: it is captured, passes
// through four lane steps (filter multiply, filter add, mapping multiply,
// mapping correction) and the merge, and only then is the next one taken. the
// result sits in an output register, so the next sample is taken while it
// waits; the merge only waits if that register still holds a result that is
// not being taken when the next result is ready. the filter state, the last
// healthy time and the brake latch clear on reset.
// configuration writes take effect at once and are meant for an idle block.
module pedal_position_plausibility_top (
    input  logic                             clk,
    input  logic                             rst_n,
    ppc_sample_if.sink                       sample,
    ppc_result_if.source                     result,
    input  logic                             write_enable,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]    write_index,
    input  logic [ppc_pkg::CFG_DATA_W-1:0]   write_data
);

    // configuration registers
    logic [ppc_pkg::ALPHA_W-1:0]  alpha_reg;
    logic [ppc_pkg::CODE_W-1:0]   one_low_reg;
    logic [ppc_pkg::CODE_W-1:0]   one_high_reg;
    logic [ppc_pkg::CODE_W-1:0]   two_low_reg;
    logic [ppc_pkg::CODE_W-1:0]   two_high_reg;
    logic [ppc_pkg::FTIME_W-1:0]  fault_time_reg;
    logic [ppc_pkg::LEVEL_W-1:0]  disagree_reg;
    logic [ppc_pkg::LEVEL_W-1:0]  throttle_on_reg;
    logic [ppc_pkg::ALPHA_W-1:0]  alpha_sat;

    // captured sample
    logic [ppc_pkg::CODE_W-1:0]   code_one_reg;
    logic [ppc_pkg::CODE_W-1:0]   code_two_reg;
    logic [ppc_pkg::BRAKE_W-1:0]  brake_front_reg;
    logic [ppc_pkg::BRAKE_W-1:0]  brake_rear_reg;
    logic [ppc_pkg::TIME_W-1:0]   now_reg;

    // sequencer
    ppc_pkg::phase_t              phase_reg;
    ppc_pkg::phase_t              phase_next;
    ppc_pkg::lane_ctrl_t          lane_ctrl;
    logic                         accept;
    logic                         merge_fire;
    logic                         out_valid_reg;
    logic                         out_valid_next;

    // lane results
    logic [ppc_pkg::LEVEL_W-1:0]  level_one;
    logic [ppc_pkg::LEVEL_W-1:0]  level_two;
    logic                         oow_one;
    logic                         oow_two;
    ppc_pkg::result_t             merged;

    // alpha above one acts as one
    assign alpha_sat = (alpha_reg > ppc_pkg::ONE_Q16) ? ppc_pkg::ONE_Q16 : alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg       <= ppc_pkg::ALPHA_W'(32768);
            one_low_reg     <= ppc_pkg::CODE_W'(100);
            one_high_reg    <= ppc_pkg::CODE_W'(4000);
            two_low_reg     <= ppc_pkg::CODE_W'(100);
            two_high_reg    <= ppc_pkg::CODE_W'(4000);
            fault_time_reg  <= ppc_pkg::FTIME_W'(100);
            disagree_reg    <= ppc_pkg::LEVEL_W'(6554);
            throttle_on_reg <= ppc_pkg::LEVEL_W'(16384);
        end
        else if (write_enable)
        begin
            case (ppc_pkg::cfg_index_t'(write_index))
                ppc_pkg::REG_FILTER_ALPHA:   alpha_reg       <= write_data;
                ppc_pkg::REG_ONE_LOW_LIMIT:  one_low_reg     <= write_data[ppc_pkg::CODE_W-1:0];
                ppc_pkg::REG_ONE_HIGH_LIMIT: one_high_reg    <= write_data[ppc_pkg::CODE_W-1:0];
                ppc_pkg::REG_TWO_LOW_LIMIT:  two_low_reg     <= write_data[ppc_pkg::CODE_W-1:0];
                ppc_pkg::REG_TWO_HIGH_LIMIT: two_high_reg    <= write_data[ppc_pkg::CODE_W-1:0];
                ppc_pkg::REG_FAULT_TIME:     fault_time_reg  <= write_data[ppc_pkg::FTIME_W-1:0];
                ppc_pkg::REG_DISAGREE_LIMIT: disagree_reg    <= write_data;
                ppc_pkg::REG_THROTTLE_ON:    throttle_on_reg <= write_data;
                default:                     ;
            endcase
        end
    end

    // input transaction: only taken between samples
    assign sample.ready = (phase_reg == ppc_pkg::PH_IDLE);
    assign accept       = sample.valid && sample.ready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_one_reg    <= sample.sensor_one_code;
            code_two_reg    <= sample.sensor_two_code;
            brake_front_reg <= sample.brake_front;
            brake_rear_reg  <= sample.brake_rear;
            now_reg         <= sample.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ppc_pkg::PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // step through the lane phases, merge once the output register is free
    always_comb
    begin
        phase_next = phase_reg;
        lane_ctrl  = '0;
        merge_fire = 1'b0;
        case (phase_reg)
            ppc_pkg::PH_IDLE:
            begin
                if (accept)
                    phase_next = ppc_pkg::PH_FILTER_MUL;
            end
            ppc_pkg::PH_FILTER_MUL:
            begin
                lane_ctrl.filter_mul = 1'b1;
                phase_next           = ppc_pkg::PH_FILTER_ADD;
            end
            ppc_pkg::PH_FILTER_ADD:
            begin
                lane_ctrl.filter_add = 1'b1;
                phase_next           = ppc_pkg::PH_MAP_MUL;
            end
            ppc_pkg::PH_MAP_MUL:
            begin
                lane_ctrl.map_mul = 1'b1;
                phase_next        = ppc_pkg::PH_MAP_FIX;
            end
            ppc_pkg::PH_MAP_FIX:
            begin
                lane_ctrl.map_fix = 1'b1;
                phase_next        = ppc_pkg::PH_MERGE;
            end
            ppc_pkg::PH_MERGE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    merge_fire = 1'b1;
                    phase_next = ppc_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = ppc_pkg::PH_IDLE;
            end
        endcase

        if (merge_fire)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    ppc_lane u_lane_one (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (lane_ctrl),
        .lane_const    (ppc_pkg::LANE_ONE),
        .alpha         (alpha_sat),
        .code          (code_one_reg),
        .low_limit     (one_low_reg),
        .high_limit    (one_high_reg),
        .level         (level_one),
        .out_of_window (oow_one)
    );

    ppc_lane u_lane_two (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (lane_ctrl),
        .lane_const    (ppc_pkg::LANE_TWO),
        .alpha         (alpha_sat),
        .code          (code_two_reg),
        .low_limit     (two_low_reg),
        .high_limit    (two_high_reg),
        .level         (level_two),
        .out_of_window (oow_two)
    );

    ppc_merge u_merge (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .load                  (merge_fire),
        .level_one             (level_one),
        .level_two             (level_two),
        .oow_one               (oow_one),
        .oow_two               (oow_two),
        .now_ms                (now_reg),
        .brake_front           (brake_front_reg),
        .brake_rear            (brake_rear_reg),
        .fault_time_ms         (fault_time_reg),
        .disagree_limit        (disagree_reg),
        .throttle_on_threshold (throttle_on_reg),
        .result                (merged)
    );

    // output transaction
    assign result.valid                = out_valid_reg;
    assign result.throttle_level       = merged.throttle_level;
    assign result.sensor_one_level     = merged.sensor_one_level;
    assign result.sensor_two_level     = merged.sensor_two_level;
    assign result.pedal_fault          = merged.pedal_fault;
    assign result.brake_conflict_fault = merged.brake_conflict_fault;

    // an accepted sample starts the lane sequence on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> phase_reg == ppc_pkg::PH_FILTER_MUL)
        else $error("accepted sample did not start the lanes");

    // a merge always leaves a result on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        merge_fire |=> result.valid)
        else $error("merged result not presented");

    // a result never overwrites one that was not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        merge_fire |-> (!out_valid_reg || result.ready))
        else $error("result overwritten before transaction");

    // levels stay within full travel
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.sensor_one_level <= ppc_pkg::ONE_Q16)
                      && (result.sensor_two_level <= ppc_pkg::ONE_Q16))
        else $error("level above full travel");

endmodule

// ===== hdl/ppc_lane.sv =====
// one sensor lane: low-pass filter state, travel mapping and window test
// depends on ppc_pkg
module ppc_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ppc_pkg::lane_ctrl_t           ctrl,
    input  ppc_pkg::lane_const_t          lane_const,
    input  logic [ppc_pkg::ALPHA_W-1:0]   alpha,
    input  logic [ppc_pkg::CODE_W-1:0]    code,
    input  logic [ppc_pkg::CODE_W-1:0]    low_limit,
    input  logic [ppc_pkg::CODE_W-1:0]    high_limit,
    output logic [ppc_pkg::LEVEL_W-1:0]   level,
    output logic                          out_of_window
);

    logic        [ppc_pkg::STATE_W-1:0]  state_reg;
    logic        [ppc_pkg::STATE_W-1:0]  state_next;
    logic signed [ppc_pkg::PROD_W-1:0]   prod_reg;
    logic signed [ppc_pkg::PROD_W-1:0]   prod_next;
    logic        [ppc_pkg::STATE_W-1:0]  dist_reg;
    logic        [ppc_pkg::MUL_W-1:0]    mul_reg;
    logic        [ppc_pkg::MUL_W-1:0]    mul_next;
    logic                                le_rest_reg;
    logic                                ge_rest_reg;
    logic                                span_hit_reg;
    logic                                oow_reg;
    logic                                oow_next;
    logic        [ppc_pkg::LEVEL_W-1:0]  level_reg;
    logic        [ppc_pkg::LEVEL_W-1:0]  level_next;

    logic signed [ppc_pkg::DIFF_W-1:0]   diff;
    logic signed [ppc_pkg::ALPHA_W:0]    alpha_s;
    logic signed [ppc_pkg::PROD_W-1:0]   rounded;
    logic signed [ppc_pkg::STATE_W+4:0]  sum_s;
    logic        [ppc_pkg::STATE_W:0]    dist_full;
    logic        [ppc_pkg::LEVEL_W-1:0]  est;
    logic        [ppc_pkg::REM_W-1:0]    est_span;
    logic        [ppc_pkg::REM_W-1:0]    remainder;
    logic        [ppc_pkg::LEVEL_W-1:0]  est_fixed;

    // filter: state + round(alpha * (code*256 - state) / 65536)
    always_comb
    begin
        diff      = $signed({2'b00, code, 8'h00}) - $signed({2'b00, state_reg});
        alpha_s   = $signed({1'b0, alpha});
        prod_next = ppc_pkg::PROD_W'(alpha_s) * ppc_pkg::PROD_W'(diff);
        rounded   = prod_reg + ppc_pkg::PROD_W'(32768);
        sum_s     = $signed({5'b00000, state_reg})
                  + (ppc_pkg::STATE_W + 5)'(rounded >>> ppc_pkg::FRAC_W);
        if (sum_s[ppc_pkg::STATE_W+4])
            state_next = '0;
        else if (|sum_s[ppc_pkg::STATE_W+3:ppc_pkg::STATE_W])
            state_next = ppc_pkg::STATE_MAX;
        else
            state_next = sum_s[ppc_pkg::STATE_W-1:0];
    end

    // mapping: estimate by reciprocal, then one remainder correction
    always_comb
    begin
        dist_full = {1'b0, state_reg} - {1'b0, lane_const.rest_q8};
        mul_next  = ppc_pkg::MUL_W'(dist_full[ppc_pkg::STATE_W-1:0])
                  * ppc_pkg::MUL_W'(lane_const.recip);
        oow_next  = (state_reg < {low_limit, 8'h00}) || (state_reg > {high_limit, 8'h00});
        est       = mul_reg[ppc_pkg::EST_LSB +: ppc_pkg::LEVEL_W];
        est_span  = ppc_pkg::REM_W'(est) * ppc_pkg::REM_W'(lane_const.span);
        remainder = ppc_pkg::REM_W'({dist_reg, 16'h0000}) - est_span;
        est_fixed = (remainder >= ppc_pkg::REM_W'(lane_const.span)) ? est + 1'b1 : est;
        if (!lane_const.span_ok)
            level_next = ge_rest_reg ? ppc_pkg::ONE_Q16 : '0;
        else if (le_rest_reg)
            level_next = '0;
        else if (span_hit_reg)
            level_next = ppc_pkg::ONE_Q16;
        else
            level_next = est_fixed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (ctrl.filter_add)
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.filter_mul)
            prod_reg <= prod_next;
        if (ctrl.map_mul)
        begin
            dist_reg     <= dist_full[ppc_pkg::STATE_W-1:0];
            mul_reg      <= mul_next;
            le_rest_reg  <= state_reg <= lane_const.rest_q8;
            ge_rest_reg  <= state_reg >= lane_const.rest_q8;
            span_hit_reg <= dist_full[ppc_pkg::STATE_W-1:0] >= lane_const.span;
            oow_reg      <= oow_next;
        end
        if (ctrl.map_fix)
            level_reg <= level_next;
    end

    assign level         = level_reg;
    assign out_of_window = oow_reg;

endmodule

// ===== hdl/ppc_merge.sv =====
// merge stage: range timeout, disagreement and brake conflict latch
// depends on ppc_pkg
module ppc_merge (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [ppc_pkg::LEVEL_W-1:0]   level_one,
    input  logic [ppc_pkg::LEVEL_W-1:0]   level_two,
    input  logic                          oow_one,
    input  logic                          oow_two,
    input  logic [ppc_pkg::TIME_W-1:0]    now_ms,
    input  logic [ppc_pkg::BRAKE_W-1:0]   brake_front,
    input  logic [ppc_pkg::BRAKE_W-1:0]   brake_rear,
    input  logic [ppc_pkg::FTIME_W-1:0]   fault_time_ms,
    input  logic [ppc_pkg::LEVEL_W-1:0]   disagree_limit,
    input  logic [ppc_pkg::LEVEL_W-1:0]   throttle_on_threshold,
    output ppc_pkg::result_t              result
);

    logic [ppc_pkg::TIME_W-1:0]   last_healthy_reg;
    logic [ppc_pkg::TIME_W-1:0]   last_healthy_next;
    logic                         latch_reg;
    logic                         latch_next;
    ppc_pkg::result_t             result_reg;
    ppc_pkg::result_t             result_next;

    logic [ppc_pkg::LEVEL_W:0]    sum;
    logic [ppc_pkg::LEVEL_W-1:0]  gap;
    logic [ppc_pkg::TIME_W-1:0]   elapsed;
    logic [ppc_pkg::BRAKE_W-1:0]  brake;
    logic                         timeout;

    always_comb
    begin
        sum     = {1'b0, level_one} + {1'b0, level_two};
        gap     = (level_one > level_two) ? level_one - level_two : level_two - level_one;
        elapsed = now_ms - last_healthy_reg;
        brake   = (brake_rear > brake_front) ? brake_rear : brake_front;
        timeout = (oow_one || oow_two) && (elapsed > ppc_pkg::TIME_W'(fault_time_ms));

        last_healthy_next = (oow_one || oow_two) ? last_healthy_reg : now_ms;

        if ((sum > {throttle_on_threshold, 1'b0}) && (brake > ppc_pkg::BRAKE_ON))
            latch_next = 1'b1;
        else if (sum < ppc_pkg::THROTTLE_LOW)
            latch_next = 1'b0;
        else
            latch_next = latch_reg;

        result_next.throttle_level       = sum[ppc_pkg::LEVEL_W:1];
        result_next.sensor_one_level     = level_one;
        result_next.sensor_two_level     = level_two;
        result_next.pedal_fault          = timeout || (gap > disagree_limit);
        result_next.brake_conflict_fault = latch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_healthy_reg <= '0;
            latch_reg        <= 1'b0;
        end
        else if (load)
        begin
            last_healthy_reg <= last_healthy_next;
            latch_reg        <= latch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule
